// File: hw/rtl/bmhq_pkg.sv
`default_nettype none

package bmhq_pkg;

  localparam int NODE_W    = 16;
  localparam int DIST_W    = 31;
  localparam int OCC_W     = 11;
  localparam int REC_W     = 2 * NODE_W + DIST_W;
  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 80;
  localparam int M_USED_W  = REC_W + OCC_W;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [NODE_W-1:0] to_node;
    logic [NODE_W-1:0] from_node;
  } rec_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } res_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_POP_TOP,
    S_POP_LAST,
    S_DN_CHK,
    S_DN_L,
    S_DN_R,
    S_DN_FIN,
    S_DONE
  } hq_state_t;

  typedef enum logic [2:0] {
    RD_ROOT,
    RD_PARENT,
    RD_LAST,
    RD_CH,
    RD_CH1
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_REC,
    WR_RD,
    WR_CAND
  } wr_sel_t;

  typedef struct packed {
    logic    load_in;
    logic    pos_init;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    pos_half;
    logic    top_load;
    logic    rec_from_rd;
    logic    init_down;
    logic    best_load;
    logic    cand_from_best;
    logic    cand_is_right;
    logic    descend;
    logic    out_load;
  } hq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_gt1;
    logic up_swap;
    logic ch_le_n;
    logic ch_lt_n;
    logic right_better;
    logic stop;
    logic cnt_nz;
    logic out_free;
  } hq_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/bmhq_ram.sv
`default_nettype none

module bmhq_ram #(
  parameter int WIDTH = 63,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bmhq_ctrl.sv
`default_nettype none

module bmhq_ctrl import bmhq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     in_pop,
  input  wire hq_stat_t dst,
  output logic          in_ready,
  output hq_cmd_t       cmd
);

  hq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (!in_pop) begin
            if (dst.full) begin
              state_next = S_DONE;
            end else begin
              cmd.pos_init = 1'b1;
              cmd.cnt_inc  = 1'b1;
              state_next   = S_UP_CHK;
            end
          end else begin
            if (dst.empty) begin
              state_next = S_DONE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_ROOT;
              state_next = S_POP_TOP;
            end
          end
        end
      end
      S_UP_CHK: begin
        if (dst.pos_gt1) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PARENT;
          state_next = S_UP_CMP;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_REC;
          state_next = S_DONE;
        end
      end
      S_UP_CMP: begin
        cmd.wr_en = 1'b1;
        if (dst.up_swap) begin
          // The parent drops into the hole and the hole climbs one level.
          cmd.wr_sel   = WR_RD;
          cmd.pos_half = 1'b1;
          state_next   = S_UP_CHK;
        end else begin
          cmd.wr_sel = WR_REC;
          state_next = S_DONE;
        end
      end
      S_POP_TOP: begin
        cmd.top_load = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RD_LAST;
        cmd.cnt_dec  = 1'b1;
        state_next   = S_POP_LAST;
      end
      S_POP_LAST: begin
        cmd.rec_from_rd = 1'b1;
        cmd.init_down   = 1'b1;
        state_next      = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (dst.ch_le_n) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_CH;
          state_next = S_DN_L;
        end else begin
          state_next = S_DN_FIN;
        end
      end
      S_DN_L: begin
        if (dst.ch_lt_n) begin
          cmd.best_load = 1'b1;
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = RD_CH1;
          state_next    = S_DN_R;
        end else if (dst.stop) begin
          state_next = S_DN_FIN;
        end else begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = WR_CAND;
          cmd.descend = 1'b1;
          state_next  = S_DN_CHK;
        end
      end
      S_DN_R: begin
        // The right child wins only when strictly smaller than the left.
        cmd.cand_from_best = !dst.right_better;
        cmd.cand_is_right  = dst.right_better;
        if (dst.stop) begin
          state_next = S_DN_FIN;
        end else begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = WR_CAND;
          cmd.descend = 1'b1;
          state_next  = S_DN_CHK;
        end
      end
      S_DN_FIN: begin
        if (dst.cnt_nz) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_REC;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (dst.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/bmhq_dp.sv
`default_nettype none

module bmhq_dp import bmhq_pkg::*; #(
  parameter int CAPACITY = 1024,
  localparam int PW  = $clog2(CAPACITY + 1),
  localparam int CHW = PW + 1,
  localparam int AW  = $clog2(CAPACITY)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hq_cmd_t           cmd,
  input  wire logic              in_pop,
  input  wire rec_t              in_rec,
  input  wire logic              out_ready,
  output hq_stat_t               dst,
  output logic      [PW-1:0]     count,
  output logic                   out_valid,
  output rec_t                   out_rec,
  output res_status_t            out_status,
  output logic      [OCC_W-1:0]  out_occ
);

  logic [PW-1:0]    pos;
  logic [CHW-1:0]   ch;
  logic [CHW-1:0]   idx;
  rec_t             rec;
  rec_t             best;
  rec_t             top;
  rec_t             rd_rec;
  rec_t             cand;
  rec_t             wr_rec;
  logic             req_pop;
  logic             err_full;
  logic             err_empty;
  logic [REC_W-1:0] ram_rd_data;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;

  assign rd_rec = rec_t'(ram_rd_data);
  assign cand   = cmd.cand_from_best ? best : rd_rec;
  assign idx    = cmd.cand_is_right ? (ch + 1'b1) : ch;

  always_comb begin
    case (cmd.rd_sel)
      RD_ROOT:   rd_addr = '0;
      RD_PARENT: rd_addr = AW'((pos >> 1) - 1'b1);
      RD_LAST:   rd_addr = AW'(count - 1'b1);
      RD_CH:     rd_addr = AW'(ch - 1'b1);
      RD_CH1:    rd_addr = AW'(ch);
      default:   rd_addr = '0;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      WR_REC:  wr_rec = rec;
      WR_RD:   wr_rec = rd_rec;
      WR_CAND: wr_rec = cand;
      default: wr_rec = rec;
    endcase
  end

  assign wr_addr = AW'(pos - 1'b1);

  bmhq_ram #(
    .WIDTH (REC_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_rec),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  assign dst.full         = (count == PW'(CAPACITY));
  assign dst.empty        = (count == '0);
  assign dst.pos_gt1      = (pos > PW'(1));
  assign dst.up_swap      = (rd_rec.distance > rec.distance);
  assign dst.ch_le_n      = (ch <= CHW'(count));
  assign dst.ch_lt_n      = (ch < CHW'(count));
  assign dst.right_better = (best.distance > rd_rec.distance);
  assign dst.stop         = (cand.distance > rec.distance);
  assign dst.cnt_nz       = (count != '0);
  assign dst.out_free     = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + 1'b1;
      end else if (cmd.cnt_dec) begin
        count <= count - 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      rec       <= in_rec;
      req_pop   <= in_pop;
      err_full  <= !in_pop && dst.full;
      err_empty <= in_pop && dst.empty;
    end else if (cmd.rec_from_rd) begin
      rec <= rd_rec;
    end
    if (cmd.pos_init) begin
      pos <= count + 1'b1;
    end else if (cmd.pos_half) begin
      pos <= pos >> 1;
    end else if (cmd.init_down) begin
      pos <= PW'(1);
    end else if (cmd.descend) begin
      pos <= PW'(idx);
    end
    if (cmd.init_down) begin
      ch <= CHW'(2);
    end else if (cmd.descend) begin
      ch <= idx << 1;
    end
    if (cmd.top_load) begin
      top <= rd_rec;
    end
    if (cmd.best_load) begin
      best <= rd_rec;
    end
    if (cmd.out_load) begin
      out_rec <= (req_pop && !err_empty) ? top : '0;
      out_occ <= OCC_W'(count);
      if (err_full) begin
        out_status <= ST_PUSH_FULL;
      end else if (err_empty) begin
        out_status <= ST_POP_EMPTY;
      end else begin
        out_status <= ST_OK;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/binary_min_heap_queue_top.sv
`default_nettype none

// Channel   Direction  Word contents (lowest bit first)
// s_axis    in         tdata: from_node, to_node, distance; tuser: req_type (1 = pop)
// m_axis    out        tdata: out_from, out_to, out_distance, occupancy; tuser: status
//
// One request is handled at a time; a word is taken only while the controller is idle.
// A push compares the new record with one parent after another while it sifts up; a pop
// reads the root and the last record, then reads the children at each level it descends.
// The single read port of the heap RAM makes each of these reads a step of its own.
// A finished result sits in the output register, so a new request can start while it waits.
// rst is synchronous; it empties the queue, and the heap RAM itself is not cleared.
// A stalled m_axis holds the controller in its final state until the result is taken.

module binary_min_heap_queue_top import bmhq_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // from_node, to_node, distance
  input  wire logic [0:0]           s_axis_tuser,  // req_type
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic      [M_TDATA_W-1:0] m_axis_tdata,  // out_from, out_to, out_distance, occupancy
  output logic      [1:0]           m_axis_tuser   // status
);

  localparam int PW = $clog2(CAPACITY + 1);

  hq_cmd_t          cmd;
  hq_stat_t         dst;
  rec_t             in_rec;
  rec_t             out_rec;
  res_status_t      out_status;
  logic [OCC_W-1:0] out_occ;
  logic [PW-1:0]    count;

  assign in_rec = rec_t'(s_axis_tdata[REC_W-1:0]);

  bmhq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_pop   (s_axis_tuser[0]),
    .dst      (dst),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  bmhq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_pop     (s_axis_tuser[0]),
    .in_rec     (in_rec),
    .out_ready  (m_axis_tready),
    .dst        (dst),
    .count      (count),
    .out_valid  (m_axis_tvalid),
    .out_rec    (out_rec),
    .out_status (out_status),
    .out_occ    (out_occ)
  );

  assign m_axis_tdata = {{(M_TDATA_W - M_USED_W){1'b0}}, out_occ, out_rec};
  assign m_axis_tuser = out_status;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= PW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] && !dst.full)
      |=> (count == $past(count) + 1'b1))
    else $error("accepted push did not add one record");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !cmd.wr_en)
    else $error("heap RAM written while idle");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> dst.out_free)
    else $error("result loaded over a word not yet taken");

endmodule

`default_nettype wire

// File: sim/tb_binary_min_heap_queue_top.sv
module tb_binary_min_heap_queue_top;
  import bmhq_pkg::*;

  localparam int          CAPACITY    = 1024;
  localparam int          HOLD_CYCLES = 400;
  localparam int          DRAIN_WAIT  = 60;
  localparam logic        REQ_PUSH    = 1'b0;
  localparam logic        REQ_POP     = 1'b1;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef struct packed {
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic [DIST_W-1:0] distance;
    res_status_t       status;
    logic [OCC_W-1:0]  occ;
  } heap_result_t;

  typedef struct packed {
    logic         req;
    rec_t         rec;
    logic         typed;
    heap_result_t want;
  } directed_row_t;

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [0:0]           s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]           m_axis_tuser;

  rec_t            heap_mem [CAPACITY];
  int unsigned     heap_count;
  heap_result_t    expected_outcomes [$];
  directed_row_t   directed_rows [$];
  int              error_count;
  int              tx_idle_pct;
  int              rx_idle_pct;
  bit              rx_hold_req;

  binary_min_heap_queue_top #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Heap position p (counted from one) lives in heap_mem[p-1].
  function automatic void heap_insert(rec_t r);
    int unsigned pos;
    heap_count++;
    pos = heap_count;
    while (pos > 1 && heap_mem[pos/2 - 1].distance > r.distance) begin
      heap_mem[pos-1] = heap_mem[pos/2 - 1];
      pos = pos / 2;
    end
    heap_mem[pos-1] = r;
  endfunction

  // The right child wins only when strictly smaller; on equal keys the child moves up.
  function automatic rec_t heap_extract_min();
    rec_t        top;
    rec_t        moved;
    int unsigned n;
    int unsigned par;
    int unsigned ch;
    bit          stop;
    top   = heap_mem[0];
    moved = heap_mem[heap_count-1];
    heap_count--;
    n    = heap_count;
    par  = 1;
    ch   = 2;
    stop = 1'b0;
    while (!stop && ch <= n) begin
      if (ch < n && heap_mem[ch-1].distance > heap_mem[ch].distance) ch++;
      if (heap_mem[ch-1].distance > moved.distance) begin
        stop = 1'b1;
      end else begin
        heap_mem[par-1] = heap_mem[ch-1];
        par = ch;
        ch  = ch * 2;
      end
    end
    if (n > 0) heap_mem[par-1] = moved;
    return top;
  endfunction

  function automatic heap_result_t serve_request(logic req, rec_t r);
    heap_result_t res;
    rec_t         top;
    res        = '0;
    res.status = ST_OK;
    if (req == REQ_PUSH) begin
      if (heap_count >= CAPACITY) res.status = ST_PUSH_FULL;
      else heap_insert(r);
    end else if (heap_count == 0) begin
      res.status = ST_POP_EMPTY;
    end else begin
      top           = heap_extract_min();
      res.from_node = top.from_node;
      res.to_node   = top.to_node;
      res.distance  = top.distance;
    end
    res.occ = OCC_W'(heap_count);
    return res;
  endfunction

  function automatic rec_t random_record();
    rec_t r;
    r.from_node = NODE_W'($urandom_range(0, 65535));
    r.to_node   = NODE_W'($urandom_range(0, 65535));
    case ($urandom_range(0, 3))
      0: r.distance = DIST_W'($urandom);
      1: r.distance = DIST_W'($urandom_range(0, 15));
      2: r.distance = $urandom_range(0, 1) ? DIST_MAX : '0;
      default: r.distance = DIST_MAX - DIST_W'($urandom_range(0, 15));
    endcase
    return r;
  endfunction

  function automatic void add_row(logic req, logic [NODE_W-1:0] f, logic [NODE_W-1:0] t,
                                  logic [DIST_W-1:0] d, logic typed, res_status_t st,
                                  logic [OCC_W-1:0] occ, logic [NODE_W-1:0] wf,
                                  logic [NODE_W-1:0] wt, logic [DIST_W-1:0] wd);
    directed_row_t row;
    row.req               = req;
    row.rec.from_node     = f;
    row.rec.to_node       = t;
    row.rec.distance      = d;
    row.typed             = typed;
    row.want.from_node    = wf;
    row.want.to_node      = wt;
    row.want.distance     = wd;
    row.want.status       = st;
    row.want.occ          = occ;
    directed_rows.push_back(row);
  endfunction

  // Offers one word, waits for the handshake and files its expected result.
  // The valid line is left high after acceptance so that back-to-back words need no toggle.
  task automatic issue_request(input logic req, input rec_t r, input logic typed,
                               input heap_result_t want);
    heap_result_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, r};
    s_axis_tuser  <= req;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = serve_request(req, r);
    expected_outcomes.push_back(typed ? want : predicted);
  endtask

  task automatic run_phase(input int n_items, input int pop_pct, input int full_pop_pct);
    logic req;
    int   pct;
    for (int i = 0; i < n_items; i++) begin
      pct = (heap_count >= CAPACITY) ? full_pop_pct : pop_pct;
      req = ($urandom_range(0, 99) < pct) ? REQ_POP : REQ_PUSH;
      issue_request(req, random_record(), 1'b0, '0);
    end
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        rx_hold_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    heap_result_t want;
    rec_t         got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[REC_W-1:0];
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected word, actual %h status %0d", $time, m_axis_tdata,
                 m_axis_tuser);
        error_count++;
      end else begin
        want = expected_outcomes.pop_front();
        if (got.from_node !== want.from_node) begin
          $display("%0t: out_from expected %h actual %h", $time, want.from_node,
                   got.from_node);
          error_count++;
        end
        if (got.to_node !== want.to_node) begin
          $display("%0t: out_to expected %h actual %h", $time, want.to_node, got.to_node);
          error_count++;
        end
        if (got.distance !== want.distance) begin
          $display("%0t: out_distance expected %h actual %h", $time, want.distance,
                   got.distance);
          error_count++;
        end
        if (m_axis_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_axis_tuser);
          error_count++;
        end
        if (m_axis_tdata[REC_W +: OCC_W] !== want.occ) begin
          $display("%0t: occupancy expected %0d actual %0d", $time, want.occ,
                   m_axis_tdata[REC_W +: OCC_W]);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_PUSH;
    heap_count    = 0;
    error_count   = 0;
    tx_idle_pct   = 14;
    rx_idle_pct   = 57;
    rx_hold_req   = 1'b0;

    // Empty pops, the field extremes, ties on the key and a final pop past empty.
    add_row(REQ_POP, '0, '0, '0, 1'b1, ST_POP_EMPTY, '0, '0, '0, '0);
    add_row(REQ_PUSH, 16'hffff, 16'h0000, DIST_MAX, 1'b1, ST_OK, OCC_W'(1), '0, '0, '0);
    add_row(REQ_PUSH, 16'h0000, 16'hffff, '0, 1'b1, ST_OK, OCC_W'(2), '0, '0, '0);
    add_row(REQ_POP, '0, '0, '0, 1'b1, ST_OK, OCC_W'(1), 16'h0000, 16'hffff, '0);
    add_row(REQ_POP, '0, '0, '0, 1'b1, ST_OK, '0, 16'hffff, 16'h0000, DIST_MAX);
    add_row(REQ_POP, 16'hffff, 16'hffff, DIST_MAX, 1'b1, ST_POP_EMPTY, '0, '0, '0, '0);
    add_row(REQ_PUSH, 16'h0001, 16'h0002, 31'd5, 1'b0, ST_OK, '0, '0, '0, '0);
    add_row(REQ_PUSH, 16'h0003, 16'h0004, 31'd5, 1'b0, ST_OK, '0, '0, '0, '0);
    add_row(REQ_PUSH, 16'h0005, 16'h0006, 31'd5, 1'b0, ST_OK, '0, '0, '0, '0);
    add_row(REQ_PUSH, 16'h0007, 16'h0008, 31'd3, 1'b0, ST_OK, '0, '0, '0, '0);
    add_row(REQ_PUSH, 16'h0009, 16'h000a, 31'd5, 1'b0, ST_OK, '0, '0, '0, '0);
    add_row(REQ_PUSH, 16'haaaa, 16'h5555, DIST_MAX, 1'b0, ST_OK, '0, '0, '0, '0);
    add_row(REQ_PUSH, 16'h5555, 16'haaaa, 31'h2aaaaaaa, 1'b0, ST_OK, '0, '0, '0, '0);
    add_row(REQ_PUSH, 16'h8000, 16'h0001, 31'h55555555, 1'b0, ST_OK, '0, '0, '0, '0);
    for (int i = 0; i < 9; i++)
      add_row(REQ_POP, '0, '0, '0, 1'b0, ST_OK, '0, '0, '0, '0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      issue_request(directed_rows[i].req, directed_rows[i].rec, directed_rows[i].typed,
                    directed_rows[i].want);

    run_phase(250, 50, 50);

    // Fill the queue to capacity and keep pushing against it; the long hold-off at the
    // start backs the block up so that it stops taking words.
    tx_idle_pct = 57;
    rx_idle_pct = 14;
    rx_hold_req = 1'b1;
    run_phase(1150, 2, 60);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(300, 80, 80);

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
